### hdl/assert_macros.svh
// Assertion macros shared by the autotile index RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, muted while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hdl/tnai_pkg.sv
// Shared types, constants and neighbour slot codes of the autotile index block.
`timescale 1ns / 1ps
`default_nettype none

package tnai_pkg;

	// Default grid geometry
	localparam int DEF_GRID_COLS = 64;
	localparam int DEF_GRID_ROWS = 32;

	// Field widths
	localparam int TILE_COL_W = 6;
	localparam int TILE_ROW_W = 5;
	localparam int IDX_W      = 5;

	// Neighbour counts
	localparam int NEIGHBOURS      = 12;
	localparam int NEAR_NEIGHBOURS = 8;
	localparam int FIRST_DIAGONAL  = 4;
	localparam int CARDINALS       = 4;

	typedef logic [NEIGHBOURS-1:0] nb_mask_t;
	typedef logic [IDX_W-1:0]      atlas_idx_t;

	// Atlas index constants
	localparam atlas_idx_t DIAGONAL_BASE = 5'd16;
	localparam atlas_idx_t FULL_INDEX    = 5'd20;
	localparam atlas_idx_t NO_INDEX      = 5'd0;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Neighbour slots: cardinal, diagonal, two steps away
	localparam int NB_N  = 0;
	localparam int NB_W  = 1;
	localparam int NB_E  = 2;
	localparam int NB_S  = 3;
	localparam int NB_NW = 4;
	localparam int NB_NE = 5;
	localparam int NB_SW = 6;
	localparam int NB_SE = 7;
	localparam int NB_NN = 8;
	localparam int NB_WW = 9;
	localparam int NB_EE = 10;
	localparam int NB_SS = 11;

	// Five-row read window around the tile, top row first
	localparam int WINDOW_ROWS = 5;
	localparam int STEP_W      = 3;
	typedef logic [STEP_W-1:0] win_row_t;
	localparam win_row_t WR_UP2 = 3'd0;
	localparam win_row_t WR_UP1 = 3'd1;
	localparam win_row_t WR_MID = 3'd2;
	localparam win_row_t WR_DN1 = 3'd3;
	localparam win_row_t WR_DN2 = 3'd4;

endpackage

`default_nettype wire

### hdl/tnai_classify.sv
// Picks the atlas variant of a tile from its twelve-neighbour presence mask.
`timescale 1ns / 1ps
`default_nettype none

module tnai_classify (
	input  wire tnai_pkg::nb_mask_t   nb_mask,
	input  wire                       tile_vis,
	output tnai_pkg::atlas_idx_t      atlas_index
);
	import tnai_pkg::*;

	logic [NEAR_NEIGHBOURS-1:0]                near_missing;
	logic [NEAR_NEIGHBOURS-FIRST_DIAGONAL-1:0] diag_missing;
	logic [1:0]                                diag_slot;

	assign near_missing = ~nb_mask[NEAR_NEIGHBOURS-1:0];
	assign diag_missing = near_missing[NEAR_NEIGHBOURS-1:FIRST_DIAGONAL];

	// Which diagonal is the lone gap
	always_comb begin
		case (diag_missing)
			4'b0001: diag_slot = 2'd0;
			4'b0010: diag_slot = 2'd1;
			4'b0100: diag_slot = 2'd2;
			4'b1000: diag_slot = 2'd3;
			default: diag_slot = 2'd0;
		endcase
	end

	// Invisible tile gives no index; else lone diagonal gap first, then fully enclosed, else the cardinal bits
	always_comb begin
		if (!tile_vis) begin
			atlas_index = NO_INDEX;
		end else if (near_missing[FIRST_DIAGONAL-1:0] == '0 && $onehot(diag_missing)) begin
			atlas_index = DIAGONAL_BASE + IDX_W'(diag_slot);
		end else if (&nb_mask) begin
			atlas_index = FULL_INDEX;
		end else begin
			atlas_index = IDX_W'(nb_mask[CARDINALS-1:0]);
		end
	end

endmodule

`default_nettype wire

### hdl/tile_neighbour_autotile_index_core.sv
// Timing: after reset the map is cleared one grid row a cycle, with the input stalled.
// A query: the map is one row-wide memory with one read port, so the five rows around the tile
// are read one per cycle, then the mask is classified. A write is a read-modify-write of the
// tile's row. A request for a tile off the grid skips the reads. A new request is taken in the
// cycle the previous result moves to the output register; the output register lets the result
// wait for the consumer while the next request is being worked on.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tile_neighbour_autotile_index_core #(
	parameter int GRID_COLS = tnai_pkg::DEF_GRID_COLS,
	parameter int GRID_ROWS = tnai_pkg::DEF_GRID_ROWS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// Request channel
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire                                op,
	input  wire [tnai_pkg::TILE_COL_W-1:0]     tile_col,
	input  wire [tnai_pkg::TILE_ROW_W-1:0]     tile_row,
	input  wire                                set_visible,
	// Result channel
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               tile_present,
	output tnai_pkg::atlas_idx_t               atlas_index,
	output tnai_pkg::nb_mask_t                 neighbour_bits
);
	import tnai_pkg::*;

	localparam int COL_W = $clog2(GRID_COLS);
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int CP_W  = ((COL_W > TILE_COL_W) ? COL_W : TILE_COL_W) + 1;
	localparam int RP_W  = ((ROW_W > TILE_ROW_W) ? ROW_W : TILE_ROW_W) + 1;
	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(GRID_ROWS - 1);
	localparam win_row_t         LAST_STEP = STEP_W'(WINDOW_ROWS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// Control
	logic [1:0]       state_q;
	win_row_t         step_q;
	logic [ROW_W-1:0] clr_row_q;
	logic             out_valid_q;

	// Request held for the duration of the item
	logic                  qry_q;
	logic                  vis_q;
	logic [TILE_COL_W-1:0] col_q;
	logic [TILE_ROW_W-1:0] row_q;
	nb_mask_t              mask_q;
	logic                  centre_q;

	// Map memory, one word per grid row
	logic [GRID_COLS-1:0] map_mem [GRID_ROWS];
	logic [GRID_COLS-1:0] rd_data_s1;
	logic                 rd_ok_s1;
	logic                 mem_re;
	logic                 mem_we;
	logic [ROW_W-1:0]     mem_raddr;
	logic [ROW_W-1:0]     mem_waddr;
	logic [GRID_COLS-1:0] mem_wdata;

	logic            accept;
	logic            out_load;
	logic            tile_in;
	logic            rd_issue;
	win_row_t        rd_off;
	logic [RP_W-1:0] rd_rp;
	logic            rd_row_ok;
	logic            cap;
	win_row_t        cap_off;
	logic [CP_W-1:0] cp_k [WINDOW_ROWS];
	logic [WINDOW_ROWS-1:0] colbit;
	atlas_idx_t      cls_index;

	// Handshake
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == ST_IDLE) || out_load);
	assign accept   = in_valid && !in_stall;
	assign tile_in  = (int'(tile_col) < GRID_COLS) && (int'(tile_row) < GRID_ROWS);

	// Row read issue: queries sweep the window, writes read the tile's own row
	assign rd_off    = qry_q ? step_q : WR_MID;
	assign rd_issue  = (state_q == ST_READ) && (qry_q ? (step_q < LAST_STEP) : (step_q == '0));
	assign rd_rp     = RP_W'(row_q) + RP_W'(rd_off);
	assign rd_row_ok = (rd_rp >= RP_W'(2)) && (int'(rd_rp) < GRID_ROWS + 2);
	assign mem_re    = rd_issue && rd_row_ok;
	assign mem_raddr = ROW_W'(rd_rp - RP_W'(2));

	// Row data is captured in the cycle after its read is issued
	assign cap     = (state_q == ST_READ) && (qry_q ? (step_q != '0) : (step_q == STEP_W'(1)));
	assign cap_off = qry_q ? (step_q - STEP_W'(1)) : WR_MID;

	// Presence of the five columns around the tile in the returned row
	always_comb begin
		for (int k = 0; k < WINDOW_ROWS; k++) begin
			cp_k[k]   = CP_W'(col_q) + CP_W'(k);
			colbit[k] = !rd_ok_s1 || !((cp_k[k] >= CP_W'(2)) && (int'(cp_k[k]) < GRID_COLS + 2))
				|| rd_data_s1[COL_W'(cp_k[k] - CP_W'(2))];
		end
	end

	// Write port: clearing pass, or the modified row of a write request
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ROW_W'(row_q);
		mem_wdata = rd_data_s1;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_row_q;
			mem_wdata = '0;
		end else if (cap && !qry_q) begin
			mem_we = 1'b1;
			mem_wdata[COL_W'(col_q)] = vis_q;
		end
	end

	// Map memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= map_mem[mem_raddr];
		end
		if (rd_issue) begin
			rd_ok_s1 <= rd_row_ok;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			clr_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + ROW_W'(1);
					if (clr_row_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= tile_in ? ST_READ : ST_DONE;
						step_q  <= '0;
					end
				end
				ST_READ: begin
					step_q <= step_q + STEP_W'(1);
					if (qry_q ? (step_q == LAST_STEP) : (step_q == STEP_W'(1))) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (accept) begin
						state_q <= tile_in ? ST_READ : ST_DONE;
						step_q  <= '0;
					end else if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture and neighbour mask assembly
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q    <= (op == OP_QUERY);
			vis_q    <= set_visible;
			col_q    <= tile_col;
			row_q    <= tile_row;
			mask_q   <= '0;
			centre_q <= 1'b0;
		end else if (cap) begin
			if (!qry_q) begin
				centre_q <= vis_q;
			end else begin
				case (cap_off)
					WR_UP2: mask_q[NB_NN] <= colbit[2];
					WR_UP1: begin
						mask_q[NB_NW] <= colbit[1];
						mask_q[NB_N]  <= colbit[2];
						mask_q[NB_NE] <= colbit[3];
					end
					WR_MID: begin
						mask_q[NB_WW] <= colbit[0];
						mask_q[NB_W]  <= colbit[1];
						centre_q      <= colbit[2];
						mask_q[NB_E]  <= colbit[3];
						mask_q[NB_EE] <= colbit[4];
					end
					WR_DN1: begin
						mask_q[NB_SW] <= colbit[1];
						mask_q[NB_S]  <= colbit[2];
						mask_q[NB_SE] <= colbit[3];
					end
					WR_DN2: mask_q[NB_SS] <= colbit[2];
					default: ;
				endcase
			end
		end
	end

	tnai_classify u_classify (
		.nb_mask     (mask_q),
		.tile_vis    (centre_q),
		.atlas_index (cls_index)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			tile_present   <= centre_q;
			atlas_index    <= qry_q ? cls_index : NO_INDEX;
			neighbour_bits <= mask_q;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	`ASSERT_NEVER(a_no_write_in_query, (state_q == ST_READ) && qry_q && mem_we, "map written during a query")
	`ASSERT_CLK(a_clear_once, (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR), "clearing pass re-entered")
	`ASSERT_CLK(a_query_full_window, (state_q == ST_DONE) && ($past(state_q) == ST_READ) && qry_q |-> ($past(step_q) == LAST_STEP), "query left the window early")
	`ASSERT_CLK(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result raised outside completion")
	`ASSERT_CLK(a_index_range, out_valid_q |-> (atlas_index <= FULL_INDEX), "atlas index out of range")

endmodule

`default_nettype wire

### tb/sv/tb_tile_neighbour_autotile_index_core.sv
// Self-checking testbench for the autotile neighbour index core: directed corner cases, then random requests.
`timescale 1ns / 1ps

module tb_tile_neighbour_autotile_index_core;
	import tnai_pkg::*;

	localparam int GRID_COLS = DEF_GRID_COLS;
	localparam int GRID_ROWS = DEF_GRID_ROWS;

	typedef struct packed {
		logic       present;
		atlas_idx_t index;
		nb_mask_t   mask;
	} tile_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  op;
	logic [TILE_COL_W-1:0] tile_col;
	logic [TILE_ROW_W-1:0] tile_row;
	logic                  set_visible;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  tile_present;
	atlas_idx_t            atlas_index;
	nb_mask_t              neighbour_bits;

	// Shadow copy of the visibility map and the results still owed by the core
	bit           vis_map [0:GRID_ROWS-1][0:GRID_COLS-1];
	tile_result_t expected_tiles [$];
	tile_result_t want;

	int  mismatch_count = 0;
	int  results_seen   = 0;
	int  items_sent     = 0;
	int  burst_left     = 0;
	bit  sender_idle    = 1'b1;
	int  stall_mode     = 0;
	int  mode_cycles    = 0;
	int  run_left       = 0;
	bit  run_level      = 1'b0;
	bit  stall_next;

	tile_neighbour_autotile_index_core #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.tile_col      (tile_col),
		.tile_row      (tile_row),
		.set_visible   (set_visible),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tile_present  (tile_present),
		.atlas_index   (atlas_index),
		.neighbour_bits(neighbour_bits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, several times the slowest legal run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int nb_col_offset(input int slot);
		case (slot)
			NB_W, NB_NW, NB_SW: return -1;
			NB_E, NB_NE, NB_SE: return 1;
			NB_WW:              return -2;
			NB_EE:              return 2;
			default:            return 0;
		endcase
	endfunction

	function automatic int nb_row_offset(input int slot);
		case (slot)
			NB_N, NB_NW, NB_NE: return -1;
			NB_S, NB_SW, NB_SE: return 1;
			NB_NN:              return -2;
			NB_SS:              return 2;
			default:            return 0;
		endcase
	endfunction

	function automatic bit on_grid(input int col, input int row);
		return col >= 0 && col < GRID_COLS && row >= 0 && row < GRID_ROWS;
	endfunction

	// Off-grid positions count as filled
	function automatic bit filled_at(input int col, input int row);
		if (!on_grid(col, row))
			return 1'b1;
		return vis_map[row][col];
	endfunction

	// Applies one request to the shadow map and returns the result it should produce
	function automatic tile_result_t autotile_outcome(input logic req_op, input int col,
			input int row, input logic vis);
		tile_result_t res;
		int near_count;
		int far_count;
		int empty_slot;
		res = '{present: 1'b0, index: NO_INDEX, mask: '0};
		near_count = 0;
		far_count  = 0;
		empty_slot = 0;
		if (!on_grid(col, row))
			return res;
		if (req_op == OP_WRITE) begin
			vis_map[row][col] = vis;
			res.present = vis;
			return res;
		end
		for (int slot = 0; slot < NEIGHBOURS; slot++) begin
			if (filled_at(col + nb_col_offset(slot), row + nb_row_offset(slot))) begin
				res.mask[slot] = 1'b1;
				if (slot < NEAR_NEIGHBOURS)
					near_count++;
				else
					far_count++;
			end else if (slot < NEAR_NEIGHBOURS) begin
				empty_slot = slot;
			end
		end
		res.present = vis_map[row][col];
		if (res.present) begin
			if (near_count == NEAR_NEIGHBOURS - 1 && empty_slot >= FIRST_DIAGONAL)
				res.index = atlas_idx_t'(DIAGONAL_BASE + empty_slot - FIRST_DIAGONAL);
			else if (near_count == NEAR_NEIGHBOURS && far_count == NEIGHBOURS - NEAR_NEIGHBOURS)
				res.index = FULL_INDEX;
			else
				res.index = atlas_idx_t'(res.mask[CARDINALS-1:0]);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int wanted);
		$display("mismatch on result %0d, %s: got %0d, expected %0d",
			results_seen, what, got, wanted);
		mismatch_count++;
	endtask

	// Hands one request to the core, in bursts with random gaps in between
	task automatic send_request(input logic req_op, input int col, input int row,
			input logic vis);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			if (!sender_idle)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		sender_idle = 1'b0;
		in_valid    <= 1'b1;
		op          <= req_op;
		tile_col    <= col[TILE_COL_W-1:0];
		tile_row    <= row[TILE_ROW_W-1:0];
		set_visible <= vis;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_tiles.push_back(autotile_outcome(req_op, col, row, vis));
		burst_left--;
		items_sent++;
	endtask

	// Sender holds off until the core has delivered everything owed
	task automatic wait_for_results();
		if (!sender_idle) begin
			in_valid    <= 1'b0;
			sender_idle = 1'b1;
		end
		burst_left = 0;
		while (expected_tiles.size() != 0) @(posedge clk);
	endtask

	// Corner tiles: off-grid neighbours, full mask, lone missing diagonal, invisible tiles
	task automatic test_corner_tiles();
		send_request(OP_QUERY, 0, 0, 1'b0);
		send_request(OP_QUERY, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
		send_request(OP_WRITE, 0, 0, 1'b1);
		send_request(OP_WRITE, 1, 0, 1'b1);
		send_request(OP_WRITE, 0, 1, 1'b1);
		send_request(OP_WRITE, 2, 0, 1'b1);
		send_request(OP_WRITE, 0, 2, 1'b1);
		send_request(OP_QUERY, 0, 0, 1'b0);
		send_request(OP_WRITE, 1, 1, 1'b1);
		send_request(OP_QUERY, 0, 0, 1'b1);
		send_request(OP_WRITE, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
		send_request(OP_QUERY, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
		send_request(OP_WRITE, GRID_COLS - 2, GRID_ROWS - 2, 1'b1);
		send_request(OP_WRITE, GRID_COLS - 1, GRID_ROWS - 2, 1'b1);
		send_request(OP_WRITE, GRID_COLS - 2, GRID_ROWS - 1, 1'b1);
		send_request(OP_WRITE, GRID_COLS - 3, GRID_ROWS - 1, 1'b1);
		send_request(OP_WRITE, GRID_COLS - 1, GRID_ROWS - 3, 1'b1);
		send_request(OP_QUERY, GRID_COLS - 1, GRID_ROWS - 1, 1'b1);
		send_request(OP_WRITE, GRID_COLS - 2, GRID_ROWS - 2, 1'b0);
		send_request(OP_QUERY, GRID_COLS - 1, GRID_ROWS - 1, 1'b0);
		send_request(OP_WRITE, 0, 0, 1'b0);
		send_request(OP_QUERY, 0, 0, 1'b1);
	endtask

	function automatic int edge_biased(input int span);
		if ($urandom_range(0, 3) != 0)
			return $urandom_range(0, span - 1);
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 1;
			2:       return span - 2;
			default: return span - 1;
		endcase
	endfunction

	// Fill a neighbourhood, knock out none, one or two neighbours, then query its centre
	task automatic test_neighbourhoods(input int item_target);
		int col;
		int row;
		int nc;
		int nr;
		int mode;
		int punch_a;
		int punch_b;
		while (items_sent < item_target) begin
			col  = edge_biased(GRID_COLS);
			row  = edge_biased(GRID_ROWS);
			mode = $urandom_range(0, 3);
			punch_a = (mode == 1) ? $urandom_range(FIRST_DIAGONAL, NEAR_NEIGHBOURS - 1)
				: $urandom_range(0, NEIGHBOURS - 1);
			if (mode == 0)
				punch_a = -1;
			punch_b = (mode == 3) ? $urandom_range(0, NEIGHBOURS - 1) : -1;
			send_request(OP_WRITE, col, row, $urandom_range(0, 9) != 0);
			for (int slot = 0; slot < NEIGHBOURS; slot++) begin
				nc = col + nb_col_offset(slot);
				nr = row + nb_row_offset(slot);
				// now and then leave a neighbour as it was
				if (on_grid(nc, nr) && $urandom_range(0, 15) != 0)
					send_request(OP_WRITE, nc, nr, slot != punch_a && slot != punch_b);
			end
			send_request(OP_QUERY, col, row, 1'($urandom_range(0, 1)));
		end
	endtask

	// Unstructured requests over the whole field ranges
	task automatic test_random_requests(input int item_target);
		while (items_sent < item_target)
			send_request(1'($urandom_range(0, 1)), $urandom_range(0, (1 << TILE_COL_W) - 1),
				$urandom_range(0, (1 << TILE_ROW_W) - 1), $urandom_range(0, 9) < 6);
	endtask

	// Result checking and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tiles.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = expected_tiles.pop_front();
				if (tile_present !== want.present)
					report_mismatch("tile_present", int'(tile_present), int'(want.present));
				if (atlas_index !== want.index)
					report_mismatch("atlas_index", int'(atlas_index), int'(want.index));
				if (neighbour_bits !== want.mask)
					report_mismatch("neighbour_bits", int'(neighbour_bits), int'(want.mask));
			end
			results_seen++;
		end
		if (mode_cycles == 0) begin
			stall_mode  = $urandom_range(0, 3);
			mode_cycles = $urandom_range(20, 200);
		end
		mode_cycles--;
		case (stall_mode)
			0: stall_next = 1'b0;
			1: stall_next = $urandom_range(0, 3) == 0;
			2: stall_next = $urandom_range(0, 9) < 7;
			default: begin
				// long runs of stall and no stall
				if (run_left == 0) begin
					run_level = !run_level;
					run_left  = $urandom_range(1, 30);
				end
				run_left--;
				stall_next = run_level;
			end
		endcase
		out_stall <= stall_next;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_WRITE;
		tile_col    = '0;
		tile_row    = '0;
		set_visible = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_corner_tiles();
		wait_for_results();
		test_neighbourhoods(1300);
		wait_for_results();
		test_random_requests(1900);
		wait_for_results();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
